>>> sv/idle_timeout_expiry_list_macros.svh
// Assertion macros for the idle timeout expiry list.
// Sampled on clk and disabled while rst_n is low in the including scope.
`ifndef IDLE_TIMEOUT_EXPIRY_LIST_MACROS_SVH
`define IDLE_TIMEOUT_EXPIRY_LIST_MACROS_SVH

// Same-cycle implication.
`define ITEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/itel_pkg.sv
// Shared types and constants for the idle timeout expiry list.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package itel_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int SLOT_W         = 6;
  localparam int TIME_W         = 32;
  localparam int CMD_W          = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd60000;

  localparam logic [CMD_W-1:0] CMD_LINK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNLINK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXPIRE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_ms;
  } itel_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] expired_slot;
    logic              expired_valid;
    logic              last;
    logic              list_empty;
  } itel_out_t;

  typedef struct packed {
    logic capture;
    logic rd_head;
    logic do_detach;
    logic do_append1;
    logic do_append2;
    logic do_pop;
    logic do_final;
  } itel_cmd_t;

  typedef struct packed {
    logic is_link;
    logic slot_ok;
    logic head_null;
    logic tail_null;
    logic head_expired;
    logic pend_valid;
    logic ob_free;
  } itel_sts_t;

endpackage

>>> sv/itel_ctrl.sv
// Sequencing controller for the idle timeout expiry list.
// Depends on itel_pkg; drives command strobes into itel_dp.
`timescale 1ns / 1ps

module itel_ctrl import itel_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  input  itel_sts_t        sts,
  output itel_cmd_t        cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DETACH    = 6'b000010,
    S_APPEND1   = 6'b000100,
    S_APPEND2   = 6'b001000,
    S_EXP_READ  = 6'b010000,
    S_EXP_CHECK = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_head = 1'b1;
    case (state_r)
      S_IDLE: begin
        cmd.rd_head = (in_command == CMD_EXPIRE);
        cmd.capture = accept;
        if (accept) begin
          case (in_command)
            CMD_LINK:   state_nxt = S_DETACH;
            CMD_UNLINK: state_nxt = S_DETACH;
            CMD_EXPIRE: state_nxt = S_EXP_CHECK;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_DETACH: begin
        cmd.do_detach = 1'b1;
        state_nxt = (sts.is_link && sts.slot_ok) ? S_APPEND1 : S_IDLE;
      end
      S_APPEND1: begin
        cmd.do_append1 = 1'b1;
        state_nxt = S_APPEND2;
      end
      S_APPEND2: begin
        cmd.do_append2 = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EXP_READ: begin
        state_nxt = S_EXP_CHECK;
      end
      S_EXP_CHECK: begin
        if (sts.head_expired) begin
          if (!sts.pend_valid || sts.ob_free) begin
            cmd.do_pop = 1'b1;
            state_nxt = S_EXP_READ;
          end
        end else if (sts.ob_free) begin
          cmd.do_final = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/itel_dp.sv
// Datapath for the idle timeout expiry list: pointer and stamp memories,
// head/tail and link flags, pending result and output register. Uses itel_pkg.
`timescale 1ns / 1ps

module itel_dp import itel_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  itel_in_t          in_data,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata,
  input  itel_cmd_t         cmd,
  output itel_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output itel_out_t         out_data
);

  localparam int IW = $clog2(SLOT_COUNT);

  typedef logic [IW:0] ptr_t;

  localparam ptr_t NIL = {1'b1, {IW{1'b0}}};

  logic [TIME_W-1:0] timeout_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TIME_W-1:0] now_r;

  ptr_t head_r, head_nxt;
  ptr_t tail_r, tail_nxt;
  logic [SLOT_COUNT-1:0] linked_r, linked_nxt;

  logic          pend_valid_r, pend_valid_nxt;
  logic [IW-1:0] pend_slot_r, pend_slot_nxt;
  logic          pend_empty_r, pend_empty_nxt;

  logic      out_valid_r, out_valid_nxt;
  itel_out_t out_data_r, out_data_nxt;

  ptr_t              next_mem  [SLOT_COUNT];
  ptr_t              prev_mem  [SLOT_COUNT];
  logic [TIME_W-1:0] stamp_mem [SLOT_COUNT];

  ptr_t              nrd_r;
  ptr_t              prd_r;
  logic [TIME_W-1:0] srd_r;

  logic [IW-1:0]     rd_addr;
  logic              nw_en, pw_en, sw_en;
  logic [IW-1:0]     nw_addr, pw_addr, sw_addr;
  ptr_t              nw_data, pw_data;
  logic [TIME_W-1:0] sw_data;

  logic [IW-1:0]     sidx;
  logic              slot_ok;
  logic              linked_hit;
  logic              ob_free;
  logic              emit;
  logic [TIME_W-1:0] idle_time;

  assign sidx       = slot_r[IW-1:0];
  assign slot_ok    = ({1'b0, slot_r} < (SLOT_W+1)'(SLOT_COUNT));
  assign linked_hit = slot_ok && linked_r[sidx];
  assign ob_free    = !out_valid_r || !out_stall;
  assign idle_time  = now_r - srd_r;
  assign rd_addr    = cmd.rd_head ? head_r[IW-1:0] : in_data.slot[IW-1:0];

  assign sts.is_link      = (cmd_r == CMD_LINK);
  assign sts.slot_ok      = slot_ok;
  assign sts.head_null    = head_r[IW];
  assign sts.tail_null    = tail_r[IW];
  assign sts.head_expired = !head_r[IW] && (idle_time >= timeout_r);
  assign sts.pend_valid   = pend_valid_r;
  assign sts.ob_free      = ob_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    linked_nxt     = linked_r;
    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_empty_nxt = pend_empty_r;
    nw_en   = 1'b0;
    nw_addr = sidx;
    nw_data = NIL;
    pw_en   = 1'b0;
    pw_addr = sidx;
    pw_data = NIL;
    sw_en   = 1'b0;
    sw_addr = sidx;
    sw_data = now_r;
    emit         = 1'b0;
    out_data_nxt = out_data_r;

    if (cmd.do_detach && linked_hit) begin
      linked_nxt[sidx] = 1'b0;
      if (!prd_r[IW]) begin
        nw_en   = 1'b1;
        nw_addr = prd_r[IW-1:0];
        nw_data = nrd_r;
      end else begin
        head_nxt = nrd_r;
      end
      if (!nrd_r[IW]) begin
        pw_en   = 1'b1;
        pw_addr = nrd_r[IW-1:0];
        pw_data = prd_r;
      end else begin
        tail_nxt = prd_r;
      end
    end

    if (cmd.do_append1) begin
      sw_en   = 1'b1;
      pw_en   = 1'b1;
      pw_data = tail_r;
      if (!tail_r[IW]) begin
        nw_en   = 1'b1;
        nw_addr = tail_r[IW-1:0];
        nw_data = {1'b0, sidx};
      end else begin
        head_nxt = {1'b0, sidx};
      end
      tail_nxt         = {1'b0, sidx};
      linked_nxt[sidx] = 1'b1;
    end

    if (cmd.do_append2) begin
      nw_en = 1'b1;
    end

    if (cmd.do_pop) begin
      head_nxt = nrd_r;
      linked_nxt[head_r[IW-1:0]] = 1'b0;
      if (nrd_r[IW]) begin
        tail_nxt = NIL;
      end else begin
        pw_en   = 1'b1;
        pw_addr = nrd_r[IW-1:0];
      end
      if (pend_valid_r) begin
        emit = 1'b1;
        out_data_nxt.expired_slot  = SLOT_W'(pend_slot_r);
        out_data_nxt.expired_valid = 1'b1;
        out_data_nxt.last          = 1'b0;
        out_data_nxt.list_empty    = pend_empty_r;
      end
      pend_valid_nxt = 1'b1;
      pend_slot_nxt  = head_r[IW-1:0];
      pend_empty_nxt = nrd_r[IW];
    end

    if (cmd.do_final) begin
      emit = 1'b1;
      out_data_nxt.last = 1'b1;
      if (pend_valid_r) begin
        out_data_nxt.expired_slot  = SLOT_W'(pend_slot_r);
        out_data_nxt.expired_valid = 1'b1;
        out_data_nxt.list_empty    = pend_empty_r;
      end else begin
        out_data_nxt.expired_slot  = '0;
        out_data_nxt.expired_valid = 1'b0;
        out_data_nxt.list_empty    = head_r[IW];
      end
      pend_valid_nxt = 1'b0;
    end

    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    nrd_r <= next_mem[rd_addr];
    prd_r <= prev_mem[rd_addr];
    srd_r <= stamp_mem[rd_addr];
    if (nw_en) begin
      next_mem[nw_addr] <= nw_data;
    end
    if (pw_en) begin
      prev_mem[pw_addr] <= pw_data;
    end
    if (sw_en) begin
      stamp_mem[sw_addr] <= sw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_data.command;
      slot_r <= in_data.slot;
      now_r  <= in_data.now_ms;
    end
    pend_slot_r  <= pend_slot_nxt;
    pend_empty_r <= pend_empty_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r    <= TIMEOUT_RST;
      head_r       <= NIL;
      tail_r       <= NIL;
      linked_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      linked_r     <= linked_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

>>> sv/idle_timeout_expiry_list.sv
// Idle timeout expiry list. Link runs detach and two append steps after transfer,
// unlink runs detach alone, command 3 does nothing; one item is in flight at a time.
// Expire pops each expired head and then gives the last result, waiting on the
// registered read of the next/stamp memories for each new head and on output room.
// Synchronous active-low reset empties the list at once, with no clearing pass,
// and loads the timeout with 60000.
`timescale 1ns / 1ps

module idle_timeout_expiry_list import itel_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itel_in_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output itel_out_t         out_data,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  `include "idle_timeout_expiry_list_macros.svh"

  itel_cmd_t ctl_cmd;
  itel_sts_t dp_sts;

  itel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_data.command),
    .sts        (dp_sts),
    .cmd        (ctl_cmd)
  );

  itel_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (ctl_cmd),
    .sts       (dp_sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `ITEL_ASSERT_IMP(a_idle_no_pend, !in_stall, !dp_sts.pend_valid, "pending result while idle")
  `ITEL_ASSERT_IMP(a_head_tail, dp_sts.head_null, dp_sts.tail_null, "tail set with empty head")
  `ITEL_ASSERT_IMP(a_pop_room, ctl_cmd.do_pop && dp_sts.pend_valid, dp_sts.ob_free, "pop without room")
  `ITEL_ASSERT_NXT(a_final_idle, ctl_cmd.do_final, !in_stall, "not idle after last result")

endmodule

>>> bench/idle_timeout_expiry_list_tb.sv
// Testbench for idle_timeout_expiry_list: a directed table, then random phases at several
// timeout settings, checked against an in-bench model of the linked expiry list.
// Depends on itel_pkg and the idle_timeout_expiry_list top level.
`timescale 1ns / 1ps

module idle_timeout_expiry_list_tb import itel_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
  localparam logic [6:0] NIL = 7'd64;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int PHASE_ITEMS = 88;

  typedef struct {
    bit                is_cfg;
    bit                typed;
    logic [TIME_W-1:0] cfg_val;
    itel_in_t          item;
    itel_out_t         want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  itel_in_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  itel_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_wdata = '0;

  // list model
  logic [6:0]        next_ref [64];
  logic [6:0]        prev_ref [64];
  logic [TIME_W-1:0] stamp_ref [64];
  bit                linked_ref [64];
  logic [6:0]        head_ref = NIL;
  logic [6:0]        tail_ref = NIL;
  logic [TIME_W-1:0] timeout_ref = TIMEOUT_RST;

  itel_out_t   expiry_batch [$];
  itel_out_t   expected_expiries [$];
  stim_row_t   directed_rows [$];
  bit          row_typed = 1'b0;
  itel_out_t   row_want = '0;
  itel_out_t   got;
  int          errors = 0;
  int          cycles = 0;
  int          stall_hold = 0;
  bit          no_idle = 1'b0;

  idle_timeout_expiry_list uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    logic stall_next;
    stall_next = out_stall;
    if (no_idle) begin
      stall_next = 1'b0;
      stall_hold = 0;
    end else if (stall_hold == 0) begin
      stall_next = ~out_stall;
      stall_hold = stall_next ? pick_gap() : $urandom_range(0, 6);
    end else begin
      stall_hold--;
    end
    out_stall <= stall_next;
  end

  task automatic detach_slot(input logic [5:0] s);
    logic [6:0] p;
    logic [6:0] n;
    p = prev_ref[s];
    n = next_ref[s];
    if (p != NIL) next_ref[p[5:0]] = n;
    else head_ref = n;
    if (n != NIL) prev_ref[n[5:0]] = p;
    else tail_ref = p;
    next_ref[s] = NIL;
    prev_ref[s] = NIL;
    linked_ref[s] = 1'b0;
  endtask

  task automatic predict_list_op(input itel_in_t it);
    logic [6:0]        h;
    logic [TIME_W-1:0] age;
    itel_out_t         r;
    int                n;
    expiry_batch.delete();
    case (it.command)
      CMD_LINK: begin
        if (linked_ref[it.slot]) detach_slot(it.slot);
        stamp_ref[it.slot] = it.now_ms;
        next_ref[it.slot] = NIL;
        prev_ref[it.slot] = tail_ref;
        if (tail_ref != NIL) next_ref[tail_ref[5:0]] = {1'b0, it.slot};
        else head_ref = {1'b0, it.slot};
        tail_ref = {1'b0, it.slot};
        linked_ref[it.slot] = 1'b1;
      end
      CMD_UNLINK: begin
        if (linked_ref[it.slot]) detach_slot(it.slot);
      end
      CMD_EXPIRE: begin
        while (head_ref != NIL) begin
          h = head_ref;
          age = it.now_ms - stamp_ref[h[5:0]];
          if (age < timeout_ref) break;
          detach_slot(h[5:0]);
          r.expired_slot = h[5:0];
          r.expired_valid = 1'b1;
          r.last = 1'b0;
          r.list_empty = (head_ref == NIL);
          expiry_batch.push_back(r);
        end
        n = expiry_batch.size();
        if (n == 0) begin
          r.expired_slot = '0;
          r.expired_valid = 1'b0;
          r.last = 1'b1;
          r.list_empty = (head_ref == NIL);
          expiry_batch.push_back(r);
        end else begin
          r = expiry_batch[n-1];
          r.last = 1'b1;
          expiry_batch[n-1] = r;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) timeout_ref = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_expiries.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          errors++;
        end else begin
          got = expected_expiries.pop_front();
          compare_field("expired_slot", 32'(got.expired_slot), 32'(out_data.expired_slot));
          compare_field("expired_valid", 32'(got.expired_valid), 32'(out_data.expired_valid));
          compare_field("last", 32'(got.last), 32'(out_data.last));
          compare_field("list_empty", 32'(got.list_empty), 32'(out_data.list_empty));
        end
      end
      if (in_valid && !in_stall) begin
        predict_list_op(in_data);
        if (row_typed) expected_expiries.push_back(row_want);
        else foreach (expiry_batch[i]) expected_expiries.push_back(expiry_batch[i]);
      end
    end
  end

  task automatic send_item(input itel_in_t it, input bit typed, input itel_out_t want);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold until every expected transfer is in and the block has settled.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_expiries.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [TIME_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input bit is_cfg, input bit typed, input logic [CMD_W-1:0] cmd,
                         input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] v,
                         input itel_out_t want);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.typed = typed;
    row.cfg_val = v;
    row.item.command = cmd;
    row.item.slot = slot;
    row.item.now_ms = v;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  initial begin
    itel_in_t          it;
    logic [TIME_W-1:0] tmo;
    logic [TIME_W-1:0] span;
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] phase_tmo [5];
    int                r;

    for (int i = 0; i < 64; i++) begin
      next_ref[i] = NIL;
      prev_ref[i] = NIL;
      stamp_ref[i] = '0;
      linked_ref[i] = 1'b0;
    end

    add_row(0, 1, CMD_EXPIRE, 6'd0, 32'd0, {6'd0, 1'b0, 1'b1, 1'b1});
    add_row(0, 0, CMD_LINK, 6'd0, 32'd0, '0);
    add_row(0, 0, CMD_LINK, 6'd63, 32'd100, '0);
    add_row(0, 1, CMD_EXPIRE, 6'd63, 32'd59999, {6'd0, 1'b0, 1'b1, 1'b0});
    add_row(0, 1, CMD_EXPIRE, 6'd0, 32'd60000, {6'd0, 1'b1, 1'b1, 1'b0});
    add_row(0, 0, CMD_LINK, 6'd5, 32'd200, '0);
    add_row(0, 0, CMD_LINK, 6'd63, 32'd300, '0);
    add_row(0, 0, CMD_UNLINK, 6'd10, 32'd0, '0);
    add_row(0, 0, CMD_LINK, 6'd1, 32'd400, '0);
    add_row(0, 0, CMD_UNLINK, 6'd5, 32'd0, '0);
    add_row(0, 0, CMD_NONE, 6'd63, 32'hFFFF_FFFF, '0);
    add_row(0, 1, CMD_EXPIRE, 6'd0, 32'd60350, {6'd63, 1'b1, 1'b1, 1'b0});
    add_row(0, 0, CMD_UNLINK, 6'd1, 32'd0, '0);
    add_row(0, 0, CMD_LINK, 6'd2, 32'hFFFF_FFF0, '0);
    add_row(0, 0, CMD_LINK, 6'd3, 32'hFFFF_FFF0, '0);
    add_row(0, 0, CMD_EXPIRE, 6'd0, 32'd59984, '0);
    add_row(1, 0, CMD_NONE, 6'd0, 32'd0, '0);
    add_row(0, 0, CMD_LINK, 6'd42, 32'hFFFF_FFFF, '0);
    add_row(0, 0, CMD_LINK, 6'd21, 32'd0, '0);
    add_row(0, 0, CMD_EXPIRE, 6'd0, 32'd0, '0);
    add_row(1, 0, CMD_NONE, 6'd0, 32'hFFFF_FFFF, '0);
    add_row(0, 0, CMD_LINK, 6'd8, 32'd1, '0);
    add_row(0, 1, CMD_EXPIRE, 6'd0, 32'd0, {6'd8, 1'b1, 1'b1, 1'b1});
    add_row(0, 1, CMD_EXPIRE, 6'd0, 32'd0, {6'd0, 1'b0, 1'b1, 1'b1});
    add_row(1, 0, CMD_NONE, 6'd0, TIMEOUT_RST, '0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_timeout(directed_rows[i].cfg_val);
      else send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    phase_tmo[0] = TIMEOUT_RST;
    phase_tmo[1] = $urandom_range(1, 2000);
    phase_tmo[2] = '0;
    phase_tmo[3] = 32'hFFFF_FFFF;
    phase_tmo[4] = $urandom;
    clock_ms = $urandom;

    for (int ph = 0; ph < 5; ph++) begin
      tmo = phase_tmo[ph];
      write_timeout(tmo);
      no_idle = (ph == 1);
      span = (tmo == 0 || tmo > 32'd3000000) ? 32'd50000 : tmo / 3 + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        it.command = (r < 45) ? CMD_LINK : (r < 65) ? CMD_UNLINK :
                     (r < 95) ? CMD_EXPIRE : CMD_NONE;
        it.slot = ($urandom_range(0, 1) != 0) ? SLOT_W'($urandom_range(0, 63)) :
                                                SLOT_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 55) clock_ms = clock_ms + $urandom_range(0, span);
        else if (r < 68) clock_ms = clock_ms;
        else if (r < 85 && head_ref != NIL)
          clock_ms = stamp_ref[head_ref[5:0]] + tmo - $urandom_range(0, 1);
        else if (r < 95) clock_ms = $urandom;
        else clock_ms = clock_ms - 1;
        it.now_ms = clock_ms;
        send_item(it, 1'b0, '0);
      end
    end

    no_idle = 1'b0;
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/itel_pkg.sv
sv/itel_ctrl.sv
sv/itel_dp.sv
sv/idle_timeout_expiry_list.sv
bench/idle_timeout_expiry_list_tb.sv
